[rtl/lzw_pkg.sv]
// Shared constants and types of the LZW decoder.
// Used by the dictionary memory, the unwind stack, the top level and the checker; no dependencies.
package lzw_pkg;

   localparam int CODE_BITS  = 16;
   localparam int MAX_STRING = 64;
   localparam int CODE_W     = 16;
   localparam int BYTE_W     = 8;
   localparam int TABLE_SIZE = 1 << CODE_BITS;
   localparam int NF_W       = CODE_BITS + 1;
   localparam int CMP_W      = CODE_W + 1;
   localparam int SP_W       = $clog2(MAX_STRING + 1);
   localparam int STK_AW     = $clog2(MAX_STRING);

   typedef logic [CODE_BITS-1:0] dict_addr_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] prefix;
      logic [BYTE_W-1:0]    suffix;
   } dict_entry_type;

   typedef struct packed {
      logic           en;
      dict_addr_type  addr;
      dict_entry_type entry;
   } dict_wr_type;

   typedef struct packed {
      logic              en;
      logic [STK_AW-1:0] addr;
      logic [BYTE_W-1:0] data;
   } stack_wr_type;

endpackage

[rtl/lzw_decoder_top.sv]
// LZW decoder for fixed 16-bit codes. Each request carries one code; the response
// stream gives the decoded string one byte per item, tlast on its final byte and tuser
// set on the single zero byte that answers a code beyond the next free entry, or equal
// to it when no entry can be added. A dictionary code is accepted, then its prefix
// chain is walked through the dictionary memory (the first read is issued, each later
// read address is taken from the previous read's prefix, then the root byte is pushed),
// then the unwind stack memory is popped, one byte per cycle while the pop is not held
// off. A single-byte code skips the dictionary reads. A repeated-pattern code pushes its
// tail byte at accept and walks the previous string. A bad code pushes one zero byte
// and goes straight to the pop. The pop waits while the response side holds off and the
// output register and the stack read register are both full. The next request is taken
// as soon as the last byte is read from the stack, while that byte may still wait in the
// stack read register or the output register. The dictionary needs no clearing after
// reset: only entries already written are ever read.
// Dictionary writes happen only in the cycle that ends a walk, when no read is issued,
// so no forwarding is needed. Depends on lzw_pkg, lzw_dict and lzw_stack.
module lzw_decoder_top
   import lzw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CODE_W-1:0] req_tdata,   // [15:0] code_word
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] data_byte
   output logic              rsp_tlast,   // last_byte
   output logic              rsp_tuser    // [0] bad_code
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_POP  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   dict_addr_type     cur_ff, cur_in;
   dict_addr_type     code_ff, code_in;
   logic              from_mem_ff, from_mem_in;
   logic [SP_W-1:0]   sp_ff, sp_in;
   logic [SP_W-1:0]   pop_ff, pop_in;
   logic              bad_ff, bad_in;
   logic [NF_W-1:0]   next_free_ff, next_free_in;
   dict_addr_type     prev_code_ff, prev_code_in;
   logic [BYTE_W-1:0] prev_first_ff, prev_first_in;
   logic              have_prev_ff, have_prev_in;
   logic [SP_W-1:0]   prev_len_ff, prev_len_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_last_ff, rd_last_in;
   logic              rd_bad_ff, rd_bad_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_bad_ff, rsp_bad_in;

   dict_wr_type       dict_wr;
   logic              dict_ren;
   dict_entry_type    dict_rd;
   stack_wr_type      stk_wr;
   logic              stk_ren;
   logic [BYTE_W-1:0] stk_rd;

   logic              req_fire;
   logic [CMP_W-1:0]  code_ext, nf_ext;
   logic              is_plain, is_repeat, can_add;
   dict_addr_type     walk_code;
   logic              is_root;
   logic [SP_W-1:0]   sp_inc, pop_dec;
   logic              out_free, move;

   lzw_dict u_dict (
      .clock   (clock),
      .wr      (dict_wr),
      .rd_en   (dict_ren),
      .rd_addr (walk_code),
      .rd_data (dict_rd)
   );

   lzw_stack u_stack (
      .clock   (clock),
      .wr      (stk_wr),
      .rd_en   (stk_ren),
      .rd_addr (pop_dec[STK_AW-1:0]),
      .rd_data (stk_rd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign code_ext   = {1'b0, req_tdata};
   assign nf_ext     = CMP_W'(next_free_ff);
   assign can_add    = have_prev_ff && (next_free_ff < NF_W'(TABLE_SIZE)) &&
                       (prev_len_ff < SP_W'(MAX_STRING));
   assign is_plain   = code_ext < nf_ext;
   assign is_repeat  = (code_ext == nf_ext) && can_add;
   assign walk_code  = from_mem_ff ? dict_rd.prefix : cur_ff;
   assign is_root    = (walk_code[CODE_BITS-1:BYTE_W] == '0);
   assign sp_inc     = sp_ff + SP_W'(1);
   assign pop_dec    = pop_ff - SP_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign move       = rd_valid_ff && out_free;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      code_in       = code_ff;
      from_mem_in   = from_mem_ff;
      sp_in         = sp_ff;
      pop_in        = pop_ff;
      bad_in        = bad_ff;
      next_free_in  = next_free_ff;
      prev_code_in  = prev_code_ff;
      prev_first_in = prev_first_ff;
      have_prev_in  = have_prev_ff;
      prev_len_in   = prev_len_ff;
      rd_last_in    = rd_last_ff;
      rd_bad_in     = rd_bad_ff;
      dict_wr       = '0;
      dict_ren      = 1'b0;
      stk_wr        = '0;
      stk_ren       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               code_in     = CODE_BITS'(req_tdata);
               bad_in      = 1'b0;
               from_mem_in = 1'b0;
               sp_in       = '0;
               priority if (is_plain) begin
                  cur_in   = CODE_BITS'(req_tdata);
                  state_in = ST_WALK;
               end else if (is_repeat) begin
                  // previous string plus its own first byte: tail byte goes in first
                  cur_in      = prev_code_ff;
                  stk_wr.en   = 1'b1;
                  stk_wr.addr = '0;
                  stk_wr.data = prev_first_ff;
                  sp_in       = SP_W'(1);
                  state_in    = ST_WALK;
               end else begin
                  stk_wr.en   = 1'b1;
                  stk_wr.addr = '0;
                  stk_wr.data = '0;
                  pop_in      = SP_W'(1);
                  bad_in      = 1'b1;
                  state_in    = ST_POP;
               end
            end
         end
         ST_WALK: begin
            if (from_mem_ff) begin
               stk_wr.en   = 1'b1;
               stk_wr.addr = sp_ff[STK_AW-1:0];
               stk_wr.data = dict_rd.suffix;
            end
            priority if (!is_root) begin
               dict_ren    = 1'b1;
               from_mem_in = 1'b1;
               sp_in       = from_mem_ff ? sp_inc : sp_ff;
            end else if (from_mem_ff) begin
               // root reached: push it next cycle
               cur_in      = walk_code;
               from_mem_in = 1'b0;
               sp_in       = sp_inc;
            end else begin
               stk_wr.en     = 1'b1;
               stk_wr.addr   = sp_ff[STK_AW-1:0];
               stk_wr.data   = walk_code[BYTE_W-1:0];
               pop_in        = sp_inc;
               if (can_add) begin
                  dict_wr.en           = 1'b1;
                  dict_wr.addr         = next_free_ff[CODE_BITS-1:0];
                  dict_wr.entry.prefix = prev_code_ff;
                  dict_wr.entry.suffix = walk_code[BYTE_W-1:0];
                  next_free_in         = next_free_ff + NF_W'(1);
               end
               prev_code_in  = code_ff;
               prev_first_in = walk_code[BYTE_W-1:0];
               have_prev_in  = 1'b1;
               prev_len_in   = sp_inc;
               state_in      = ST_POP;
            end
         end
         ST_POP: begin
            if ((pop_ff != '0) && (!rd_valid_ff || out_free)) begin
               stk_ren    = 1'b1;
               pop_in     = pop_dec;
               rd_last_in = (pop_ff == SP_W'(1));
               rd_bad_in  = bad_ff;
               if (pop_ff == SP_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold the stack byte until the output register can take it
   assign rd_valid_in = stk_ren || (rd_valid_ff && !out_free);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      priority if (move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = stk_rd;
         rsp_last_in  = rd_last_ff;
         rsp_bad_in   = rd_bad_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         from_mem_ff   <= 1'b0;
         sp_ff         <= '0;
         pop_ff        <= '0;
         next_free_ff  <= NF_W'(256);
         prev_code_ff  <= '0;
         prev_first_ff <= '0;
         have_prev_ff  <= 1'b0;
         prev_len_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         from_mem_ff   <= from_mem_in;
         sp_ff         <= sp_in;
         pop_ff        <= pop_in;
         next_free_ff  <= next_free_in;
         prev_code_ff  <= prev_code_in;
         prev_first_ff <= prev_first_in;
         have_prev_ff  <= have_prev_in;
         prev_len_ff   <= prev_len_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      code_ff     <= code_in;
      bad_ff      <= bad_in;
      rd_last_ff  <= rd_last_in;
      rd_bad_ff   <= rd_bad_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_bad_ff;

endmodule

[rtl/lzw_dict.sv]
// Dictionary memory: prefix code and suffix byte per entry, one write and one read port.
// Read data is registered and holds until the next read. Depends on lzw_pkg.
module lzw_dict
   import lzw_pkg::*;
(
   input  logic           clock,
   input  dict_wr_type    wr,
   input  logic           rd_en,
   input  dict_addr_type  rd_addr,
   output dict_entry_type rd_data
);

   dict_entry_type mem [TABLE_SIZE];
   dict_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lzw_stack.sv]
// Unwind stack memory: bytes of one string pushed tail first, popped head first.
// Read data is registered and holds until the next read. Depends on lzw_pkg.
module lzw_stack
   import lzw_pkg::*;
(
   input  logic              clock,
   input  stack_wr_type      wr,
   input  logic              rd_en,
   input  logic [STK_AW-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [MAX_STRING];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lzw_decoder_checker.sv]
// Port-level checks of the LZW decoder, attached to the top level by bind.
// Depends on lzw_pkg and lzw_decoder_top.
module lzw_decoder_checker
   import lzw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [CODE_W-1:0] req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [BYTE_W-1:0] rsp_tdata,
   input logic              rsp_tlast,
   input logic              rsp_tuser
);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // a bad code answers with one zero byte that closes its string
   a_bad_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata == '0))
      else $error("bad-code byte not a lone zero");

   // every taken request leaves the block busy: two requests are never taken back to back
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // out of reset: idle and nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind lzw_decoder_top lzw_decoder_checker u_lzw_checker (.*);
